@@ sv/shape_pair_overlap_test_unit_assert.svh @@
// assertion macros for the shape pair overlap test unit
// both expect aclk and aresetn in scope
`ifndef SHAPE_PAIR_OVERLAP_TEST_UNIT_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_TEST_UNIT_ASSERT_SVH

// same-cycle implication
`define SPOT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spot: same-cycle check failed");

// next-cycle implication
`define SPOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spot: next-cycle check failed");

`endif

@@ sv/spot_pkg.sv @@
`default_nettype none

package spot_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = 12;

    // doubled point: 2*coord + size, with headroom for 2*coord + 2*size
    localparam int PT_BITS   = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 3;
    localparam int DIFF_BITS = PT_BITS + 1;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int RAD_BITS  = SIZE_BITS + 1;
    localparam int RSQ_BITS  = 2 * RAD_BITS;

    typedef enum logic [1:0] {
        SHAPE_RECT   = 2'd0,
        SHAPE_CIRCLE = 2'd1,
        SHAPE_OTHER  = 2'd2
    } shape_kind_t;

    typedef enum logic [1:0] {
        TEST_BOX_BOX       = 2'd0,
        TEST_CIRCLE_CIRCLE = 2'd1,
        TEST_BOX_CIRCLE    = 2'd2,
        TEST_NONE          = 2'd3
    } test_t;

    typedef struct packed {
        logic [1:0]                    first_shape;
        logic signed [COORD_BITS-1:0]  first_x;
        logic signed [COORD_BITS-1:0]  first_y;
        logic [SIZE_BITS-1:0]          first_w;
        logic [SIZE_BITS-1:0]          first_h;
        logic [1:0]                    second_shape;
        logic signed [COORD_BITS-1:0]  second_x;
        logic signed [COORD_BITS-1:0]  second_y;
        logic [SIZE_BITS-1:0]          second_w;
        logic [SIZE_BITS-1:0]          second_h;
    } in_item_t;

    typedef struct packed {
        logic  hit;
        test_t test_used;
    } out_item_t;

    // after operand selection: point against the interval [lo, hi] per axis
    typedef struct packed {
        test_t                      test;
        logic                       box_hit;
        logic signed [PT_BITS-1:0]  pt_x;
        logic signed [PT_BITS-1:0]  lo_x;
        logic signed [PT_BITS-1:0]  hi_x;
        logic signed [PT_BITS-1:0]  pt_y;
        logic signed [PT_BITS-1:0]  lo_y;
        logic signed [PT_BITS-1:0]  hi_y;
        logic [RAD_BITS-1:0]        rad;
    } prep_t;

    typedef struct packed {
        test_t                        test;
        logic                         box_hit;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        logic [RAD_BITS-1:0]          rad;
    } dist_t;

    typedef struct packed {
        test_t                test;
        logic                 box_hit;
        logic [SQ_BITS-1:0]   dx2;
        logic [SQ_BITS-1:0]   dy2;
        logic [RSQ_BITS-1:0]  rsq;
    } sq_t;

endpackage

`default_nettype wire

@@ sv/spot_prep.sv @@
`default_nettype none

module spot_prep (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spot_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spot_pkg::prep_t        out_data
);

    localparam int PW = spot_pkg::PT_BITS;
    localparam int RW = spot_pkg::RAD_BITS;

    logic                 valid_reg;
    spot_pkg::prep_t      data_reg;
    spot_pkg::prep_t      data_next;
    spot_pkg::shape_kind_t ka;
    spot_pkg::shape_kind_t kb;

    logic signed [PW-1:0] ax2, ay2, aw, ah, bx2, by2, bw, bh;
    logic signed [PW-1:0] a_right, a_bottom, b_right, b_bottom;
    logic signed [PW-1:0] ca_x, ca_y, cb_x, cb_y;

    always_comb begin
        unique case (in_data.first_shape)
            spot_pkg::SHAPE_RECT:   ka = spot_pkg::SHAPE_RECT;
            spot_pkg::SHAPE_CIRCLE: ka = spot_pkg::SHAPE_CIRCLE;
            default:                ka = spot_pkg::SHAPE_OTHER;
        endcase
        unique case (in_data.second_shape)
            spot_pkg::SHAPE_RECT:   kb = spot_pkg::SHAPE_RECT;
            spot_pkg::SHAPE_CIRCLE: kb = spot_pkg::SHAPE_CIRCLE;
            default:                kb = spot_pkg::SHAPE_OTHER;
        endcase
    end

    // everything in doubled units, one fractional bit
    always_comb begin
        ax2 = PW'(in_data.first_x) <<< 1;
        ay2 = PW'(in_data.first_y) <<< 1;
        bx2 = PW'(in_data.second_x) <<< 1;
        by2 = PW'(in_data.second_y) <<< 1;
        aw  = signed'(PW'(in_data.first_w));
        ah  = signed'(PW'(in_data.first_h));
        bw  = signed'(PW'(in_data.second_w));
        bh  = signed'(PW'(in_data.second_h));

        a_right  = ax2 + (aw <<< 1);
        a_bottom = ay2 + (ah <<< 1);
        b_right  = bx2 + (bw <<< 1);
        b_bottom = by2 + (bh <<< 1);

        ca_x = ax2 + aw;
        ca_y = ay2 + ah;
        cb_x = bx2 + bw;
        cb_y = by2 + bh;
    end

    always_comb begin
        data_next.box_hit = (a_right >= bx2) && (b_right >= ax2) &&
                            (a_bottom >= by2) && (b_bottom >= ay2);

        // default arrangement is circle against circle: interval shrinks to a point
        data_next.test = spot_pkg::TEST_NONE;
        data_next.pt_x = ca_x;
        data_next.pt_y = ca_y;
        data_next.lo_x = cb_x;
        data_next.hi_x = cb_x;
        data_next.lo_y = cb_y;
        data_next.hi_y = cb_y;
        data_next.rad  = RW'(in_data.first_w) + RW'(in_data.second_w);

        if (ka == spot_pkg::SHAPE_CIRCLE && kb == spot_pkg::SHAPE_RECT) begin
            data_next.test = spot_pkg::TEST_BOX_CIRCLE;
            data_next.lo_x = bx2;
            data_next.hi_x = b_right;
            data_next.lo_y = by2;
            data_next.hi_y = b_bottom;
            data_next.rad  = RW'(in_data.first_w);
        end else if (ka == spot_pkg::SHAPE_RECT && kb == spot_pkg::SHAPE_CIRCLE) begin
            data_next.test = spot_pkg::TEST_BOX_CIRCLE;
            data_next.pt_x = cb_x;
            data_next.pt_y = cb_y;
            data_next.lo_x = ax2;
            data_next.hi_x = a_right;
            data_next.lo_y = ay2;
            data_next.hi_y = a_bottom;
            data_next.rad  = RW'(in_data.second_w);
        end else if (ka == spot_pkg::SHAPE_CIRCLE && kb == spot_pkg::SHAPE_CIRCLE) begin
            data_next.test = spot_pkg::TEST_CIRCLE_CIRCLE;
        end else if (ka == spot_pkg::SHAPE_RECT && kb == spot_pkg::SHAPE_RECT) begin
            data_next.test = spot_pkg::TEST_BOX_BOX;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/spot_dist.sv @@
`default_nettype none

module spot_dist (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire spot_pkg::prep_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spot_pkg::dist_t       out_data
);

    localparam int PW = spot_pkg::PT_BITS;
    localparam int DW = spot_pkg::DIFF_BITS;

    logic            valid_reg;
    spot_pkg::dist_t data_reg;
    spot_pkg::dist_t data_next;

    // distance from a point to the nearest point of [lo, hi]
    function automatic logic signed [DW-1:0] clamp_diff(
        input logic signed [PW-1:0] pt,
        input logic signed [PW-1:0] lo,
        input logic signed [PW-1:0] hi
    );
        logic signed [DW-1:0] res;
        if (pt > hi) begin
            res = DW'(pt) - DW'(hi);
        end else if (pt < lo) begin
            res = DW'(pt) - DW'(lo);
        end else begin
            res = '0;
        end
        return res;
    endfunction

    always_comb begin
        data_next.test    = in_data.test;
        data_next.box_hit = in_data.box_hit;
        data_next.rad     = in_data.rad;
        data_next.dx      = clamp_diff(in_data.pt_x, in_data.lo_x, in_data.hi_x);
        data_next.dy      = clamp_diff(in_data.pt_y, in_data.lo_y, in_data.hi_y);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/spot_square.sv @@
`default_nettype none

module spot_square (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire spot_pkg::dist_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spot_pkg::sq_t         out_data
);

    localparam int SW = spot_pkg::SQ_BITS;
    localparam int QW = spot_pkg::RSQ_BITS;

    logic                 valid_reg;
    spot_pkg::sq_t        data_reg;
    spot_pkg::sq_t        data_next;
    logic signed [SW-1:0] dx_prod;
    logic signed [SW-1:0] dy_prod;

    always_comb begin
        dx_prod = SW'(in_data.dx) * SW'(in_data.dx);
        dy_prod = SW'(in_data.dy) * SW'(in_data.dy);

        data_next.test    = in_data.test;
        data_next.box_hit = in_data.box_hit;
        // squares are never negative
        data_next.dx2     = unsigned'(dx_prod);
        data_next.dy2     = unsigned'(dy_prod);
        data_next.rsq     = QW'(in_data.rad) * QW'(in_data.rad);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/shape_pair_overlap_test_unit.sv @@
// channel  | direction | ports                     | payload
// ---------+-----------+---------------------------+---------------------------
// s_       | in        | s_valid, s_ready, s_data  | two shapes: kind, x, y, w, h
// m_       | out       | m_valid, m_ready, m_data  | hit, test_used
//
// four register stages: operand select, clamp and difference, squaring,
// sum and compare into the output register
// one transaction in and one out per cycle while m_ready does not stall the output, set by the stage handshake
// each stage holds while the one after it is full and stalled, so a bubble
// anywhere lets a new transaction in even while a result waits on m_ready
// aresetn (synchronous) empties every stage; no clearing pass
`default_nettype none

`include "shape_pair_overlap_test_unit_assert.svh"

module shape_pair_overlap_test_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire spot_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output spot_pkg::out_item_t      m_data
);

    localparam int UW = spot_pkg::SUM_BITS;

    logic                p_valid;
    logic                p_ready;
    spot_pkg::prep_t     p_data;
    logic                d_valid;
    logic                d_ready;
    spot_pkg::dist_t     d_data;
    logic                q_valid;
    logic                q_ready;
    spot_pkg::sq_t       q_data;

    logic                out_valid_reg;
    spot_pkg::out_item_t out_data_reg;
    spot_pkg::out_item_t out_data_next;
    logic [UW-1:0]       dist_sum;
    logic [UW-1:0]       rad_sq;

    spot_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data)
    );

    spot_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (p_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    spot_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_data   (d_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    always_comb begin
        dist_sum = UW'(q_data.dx2) + UW'(q_data.dy2);
        rad_sq   = UW'(q_data.rsq);

        out_data_next.test_used = q_data.test;
        unique case (q_data.test)
            spot_pkg::TEST_BOX_BOX:       out_data_next.hit = q_data.box_hit;
            spot_pkg::TEST_CIRCLE_CIRCLE: out_data_next.hit = (dist_sum <= rad_sq);
            // box against circle is strict
            spot_pkg::TEST_BOX_CIRCLE:    out_data_next.hit = (dist_sum < rad_sq);
            default:                      out_data_next.hit = 1'b0;
        endcase
    end

    assign q_ready = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_ready) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            out_data_reg <= out_data_next;
        end
    end

    `SPOT_ASSERT_NOW(a_none_never_hits,
        m_valid && m_data.test_used == spot_pkg::TEST_NONE, !m_data.hit)

    `SPOT_ASSERT_NOW(a_empty_out_accepts, !m_valid, s_ready)

    `SPOT_ASSERT_NEXT(a_other_kind_unsupported,
        s_valid && s_ready && (s_data.first_shape == spot_pkg::SHAPE_OTHER ||
                               s_data.second_shape == spot_pkg::SHAPE_OTHER),
        p_valid && p_data.test == spot_pkg::TEST_NONE)

    `SPOT_ASSERT_NEXT(a_square_feeds_output,
        q_valid && q_ready, m_valid && m_data.test_used == $past(q_data.test))

endmodule

`default_nettype wire
